// ===== design/smrh_pkg.sv =====
package smrh_pkg;

  localparam logic [63:0] P1 = 64'd11400714785074694791;
  localparam logic [63:0] P2 = 64'd14029467366897019727;
  localparam logic [63:0] P3 = 64'd1609587929392839161;
  localparam logic [63:0] P4 = 64'd9650029242287828579;
  localparam logic [63:0] P5 = 64'd2870177450012600261;

  localparam logic [3:0] FULL_WORD_BYTES = 4'd8;
  localparam logic [3:0] CHUNK_BYTES     = 4'd4;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_LANE   = 9'b000000010,
    ST_FIN    = 9'b000000100,
    ST_MERGE  = 9'b000001000,
    ST_ADDLEN = 9'b000010000,
    ST_TAIL   = 9'b000100000,
    ST_QUAD   = 9'b001000000,
    ST_BYTE   = 9'b010000000,
    ST_AVAL   = 9'b100000000
  } smrh_state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } smrh_mul_req_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
    logic [127:0] dbl;
    dbl = {x, x} << r;
    return dbl[127:64];
  endfunction

endpackage

// ===== design/smrh_mul.sv =====
// 64x64 -> low 64 bit multiplier, one 32x32 partial product per cycle.
module smrh_mul (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  smrh_pkg::smrh_mul_req_t req_i,
  output logic                   done_o,
  output logic [63:0]            prod_o
);
  import smrh_pkg::*;

  logic [2:0]  ph_q;
  logic [63:0] a_q, b_q, pp_q, acc_q;
  logic        done_q;
  logic [31:0] m_a, m_b;
  logic [63:0] pp_d;

  // phase 1: lo*lo, phase 2: hi*lo, phase 3: lo*hi
  assign m_a  = (ph_q == 3'd2) ? a_q[63:32] : a_q[31:0];
  assign m_b  = (ph_q == 3'd3) ? b_q[63:32] : b_q[31:0];
  assign pp_d = m_a * m_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= 3'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        ph_q <= 3'd1;
      end else if (ph_q == 3'd4) begin
        ph_q   <= 3'd0;
        done_q <= 1'b1;
      end else if (ph_q != 3'd0) begin
        ph_q <= ph_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end
    if (ph_q != 3'd0 && ph_q != 3'd4) pp_q <= pp_d;
    if (ph_q == 3'd2) acc_q <= pp_q;
    if (ph_q == 3'd3 || ph_q == 3'd4) acc_q <= acc_q + {pp_q[31:0], 32'd0};
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== design/streaming_64bit_multiply_rotate_hash_unit.sv =====
// Channel  Dir  Signals                                        Handshake
// in       in   data_word_i valid_bytes_i last_word_i           in_valid_i / in_stall_o
// out      out  hash_value_o                                   out_valid_o / out_stall_i
// cfg      in   cfg_seed_i                                     cfg_valid_i / cfg_ready_o
//
// Every multiply goes through one shared 64-bit multiplier built from 32x32
// partial products; each multiply runs issue, 4 phases, writeback.
// A word that only fills the stripe buffer is stored when it is accepted; the
// word that closes a stripe is accepted, then runs 4 lanes x 2 multiplies.
// The last word adds the finish: merge after a full stripe (4 x 3 multiplies), tail words
// (3 each), 4-byte chunk (2), single bytes (2 each), avalanche (2).
// Reset (async, active low) clears control, seed and counters; the stripe
// buffer is not cleared. A stalled result sits in the output register
// while the next message is already taken in.
module streaming_64bit_multiply_rotate_hash_unit #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_seed_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);
  import smrh_pkg::*;

  smrh_state_e state_q, state_d;
  logic [1:0]  step_q, step_d;
  logic [2:0]  idx_q, idx_d;       // lane / tail word index, byte offset
  logic        pend_q, pend_d;     // multiply in flight
  logic [63:0] acc_q [4];
  logic [63:0] acc_d [4];
  logic [63:0] buf_q [3];
  logic [63:0] buf_d [3];
  logic [1:0]  cnt_q, cnt_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic        inmsg_q, inmsg_d;
  logic        sdone_q, sdone_d;
  logic [63:0] w_q, w_d;
  logic [3:0]  nb_q, nb_d;
  logic        last_q, last_d;
  logic [63:0] t_q, t_d;
  logic [63:0] h_q, h_d;
  logic [63:0] seed_q;
  logic        out_valid_q, out_valid_d;
  logic [63:0] hash_q, hash_d;

  smrh_mul_req_t mreq;
  logic          mdone;
  logic [63:0]   mres;
  logic          done;

  smrh_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .done_o (mdone),
    .prod_o (mres)
  );

  assign done = pend_q && mdone;

  always_comb begin
    logic [3:0]  nb;
    logic [1:0]  cnt_e;
    logic [LENGTH_BITS-1:0] len_e;
    logic [63:0] wm;
    logic [63:0] word;
    logic [3:0]  rem;
    logic [1:0]  j;

    state_d     = state_q;
    step_d      = step_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    acc_d       = acc_q;
    buf_d       = buf_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    inmsg_d     = inmsg_q;
    sdone_d     = sdone_q;
    w_d         = w_q;
    nb_d        = nb_q;
    last_d      = last_q;
    t_d         = t_q;
    h_d         = h_q;
    hash_d      = hash_q;
    out_valid_d = out_valid_q;
    mreq        = '0;
    j           = idx_q[1:0];
    rem         = (nb_q < FULL_WORD_BYTES) ? nb_q : 4'd0;
    nb          = FULL_WORD_BYTES;
    cnt_e       = cnt_q;
    len_e       = len_q;
    wm          = data_word_i;
    word        = w_q;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (done) pend_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!inmsg_q) begin
            acc_d[0] = seed_q + P1 + P2;
            acc_d[1] = seed_q + P2;
            acc_d[2] = seed_q;
            acc_d[3] = seed_q - P1;
            cnt_e    = 2'd0;
            len_e    = '0;
            sdone_d  = 1'b0;
            inmsg_d  = 1'b1;
          end
          if (last_word_i)
            nb = (valid_bytes_i > FULL_WORD_BYTES) ? FULL_WORD_BYTES : valid_bytes_i;
          if (nb < FULL_WORD_BYTES)
            wm = data_word_i & ((64'd1 << {nb[2:0], 3'd0}) - 64'd1);
          w_d    = wm;
          nb_d   = nb;
          last_d = last_word_i;
          len_d  = len_e + LENGTH_BITS'(nb);
          cnt_d  = cnt_e;
          if (nb == FULL_WORD_BYTES && cnt_e == 2'd3) begin
            state_d = ST_LANE;
            idx_d   = 3'd0;
            step_d  = 2'd0;
          end else begin
            if (nb == FULL_WORD_BYTES) begin
              buf_d[cnt_e] = wm;
              cnt_d        = cnt_e + 2'd1;
            end
            if (last_word_i) state_d = ST_FIN;
          end
        end
      end

      ST_LANE: begin
        case (j)
          2'd0:    word = buf_q[0];
          2'd1:    word = buf_q[1];
          2'd2:    word = buf_q[2];
          default: word = w_q;
        endcase
        if (step_q == 2'd0) begin
          if (!pend_q) mreq = '{start: 1'b1, a: word, b: P2};
          if (done) begin
            t_d    = rotl(acc_q[j] + mres, 6'd31);
            step_d = 2'd1;
          end
        end else begin
          if (!pend_q) mreq = '{start: 1'b1, a: t_q, b: P1};
          if (done) begin
            acc_d[j] = mres;
            step_d   = 2'd0;
            if (j == 2'd3) begin
              cnt_d   = 2'd0;
              sdone_d = 1'b1;
              state_d = last_q ? ST_FIN : ST_IDLE;
            end else begin
              idx_d = idx_q + 3'd1;
            end
          end
        end
      end

      ST_FIN: begin
        step_d = 2'd0;
        idx_d  = 3'd0;
        if (sdone_q) begin
          h_d = rotl(acc_q[0], 6'd1) + rotl(acc_q[1], 6'd7) +
                rotl(acc_q[2], 6'd12) + rotl(acc_q[3], 6'd18);
          state_d = ST_MERGE;
        end else begin
          h_d     = acc_q[2] + P5;
          state_d = ST_ADDLEN;
        end
      end

      ST_MERGE: begin
        case (step_q)
          2'd0: begin
            if (!pend_q) mreq = '{start: 1'b1, a: acc_q[j], b: P2};
            if (done) begin
              t_d    = rotl(mres, 6'd31);
              step_d = 2'd1;
            end
          end
          2'd1: begin
            if (!pend_q) mreq = '{start: 1'b1, a: t_q, b: P1};
            if (done) begin
              h_d    = h_q ^ mres;
              step_d = 2'd2;
            end
          end
          default: begin
            if (!pend_q) mreq = '{start: 1'b1, a: h_q, b: P1};
            if (done) begin
              h_d    = mres + P4;
              step_d = 2'd0;
              if (j == 2'd3) state_d = ST_ADDLEN;
              else           idx_d   = idx_q + 3'd1;
            end
          end
        endcase
      end

      ST_ADDLEN: begin
        h_d     = h_q + 64'(len_q);
        idx_d   = 3'd0;
        step_d  = 2'd0;
        state_d = ST_TAIL;
      end

      ST_TAIL: begin
        case (j)
          2'd0:    word = buf_q[0];
          2'd1:    word = buf_q[1];
          default: word = buf_q[2];
        endcase
        case (step_q)
          2'd0: begin
            if (idx_q >= {1'b0, cnt_q}) begin
              idx_d   = 3'd0;
              state_d = (rem >= CHUNK_BYTES) ? ST_QUAD : ST_BYTE;
            end else begin
              if (!pend_q) mreq = '{start: 1'b1, a: word, b: P2};
              if (done) begin
                t_d    = rotl(mres, 6'd31);
                step_d = 2'd1;
              end
            end
          end
          2'd1: begin
            if (!pend_q) mreq = '{start: 1'b1, a: t_q, b: P1};
            if (done) begin
              h_d    = h_q ^ mres;
              step_d = 2'd2;
            end
          end
          default: begin
            if (!pend_q) mreq = '{start: 1'b1, a: rotl(h_q, 6'd27), b: P1};
            if (done) begin
              h_d    = mres + P4;
              step_d = 2'd0;
              idx_d  = idx_q + 3'd1;
            end
          end
        endcase
      end

      ST_QUAD: begin
        if (step_q == 2'd0) begin
          if (!pend_q) mreq = '{start: 1'b1, a: {32'd0, w_q[31:0]}, b: P1};
          if (done) begin
            h_d    = h_q ^ mres;
            step_d = 2'd1;
          end
        end else begin
          if (!pend_q) mreq = '{start: 1'b1, a: rotl(h_q, 6'd23), b: P2};
          if (done) begin
            h_d     = mres + P3;
            step_d  = 2'd0;
            idx_d   = 3'd4;
            state_d = ST_BYTE;
          end
        end
      end

      ST_BYTE: begin
        word = (w_q >> {idx_q, 3'd0}) & 64'hFF;
        if (step_q == 2'd0) begin
          if ({1'b0, idx_q} >= rem) begin
            state_d = ST_AVAL;
          end else begin
            if (!pend_q) mreq = '{start: 1'b1, a: word, b: P5};
            if (done) begin
              h_d    = h_q ^ mres;
              step_d = 2'd1;
            end
          end
        end else begin
          if (!pend_q) mreq = '{start: 1'b1, a: rotl(h_q, 6'd11), b: P1};
          if (done) begin
            h_d    = mres;
            step_d = 2'd0;
            idx_d  = idx_q + 3'd1;
          end
        end
      end

      ST_AVAL: begin
        if (step_q == 2'd0) begin
          if (!pend_q) mreq = '{start: 1'b1, a: h_q ^ (h_q >> 33), b: P2};
          if (done) begin
            h_d    = mres ^ (mres >> 29);
            step_d = 2'd1;
          end
        end else begin
          // wait for the output register to drain before the last multiply
          if (!pend_q && !out_valid_q) mreq = '{start: 1'b1, a: h_q, b: P3};
          if (done) begin
            hash_d      = mres ^ (mres >> 32);
            out_valid_d = 1'b1;
            step_d      = 2'd0;
            inmsg_d     = 1'b0;
            cnt_d       = 2'd0;
            state_d     = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (mreq.start) pend_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 2'd0;
      idx_q       <= 3'd0;
      pend_q      <= 1'b0;
      cnt_q       <= 2'd0;
      len_q       <= '0;
      inmsg_q     <= 1'b0;
      sdone_q     <= 1'b0;
      seed_q      <= 64'd0;
      out_valid_q <= 1'b0;
      acc_q       <= '{default: 64'd0};
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      inmsg_q     <= inmsg_d;
      sdone_q     <= sdone_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      if (cfg_valid_i) seed_q <= cfg_seed_i;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    w_q    <= w_d;
    nb_q   <= nb_d;
    last_q <= last_d;
    t_q    <= t_d;
    h_q    <= h_d;
    hash_q <= hash_d;
  end

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

  // a product only arrives for a request that is still outstanding
  a_done_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdone |-> pend_q) else $error("multiplier result without request");

  // a new result only comes out of the avalanche
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_AVAL))
    else $error("result raised outside avalanche");

  // between messages the stripe buffer is empty
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !inmsg_q) |-> cnt_q == 2'd0)
    else $error("stripe buffer not empty between messages");

  // no request taken while the multiplier is busy
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> in_stall_o) else $error("request taken during multiply");

endmodule
